FILE: sv/page_table_translate_assert.svh
// ---------------------------------------------------------------------------
// page_table_translate assertion macros
// Shorthand for clocked assertions, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_TRANSLATE_ASSERT_SVH
`define PAGE_TABLE_TRANSLATE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ptt_pkg.sv
// ---------------------------------------------------------------------------
// ptt_pkg
// Shared constants and codes of the page table translator.
// ---------------------------------------------------------------------------
package ptt_pkg;

  // default geometry
  localparam int PAGE_WORDS_DEF = 8;
  localparam int NUM_PAGES_DEF  = 128;
  localparam int NUM_FRAMES_DEF = 16;

  // fixed port widths
  localparam int ACT_W      = 2;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 32;
  localparam int FRAME_IN_W = 4;
  localparam int STATUS_W   = 2;
  localparam int FPAGE_W    = 7;
  localparam int STAMP_W    = 32;

  // request actions
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MAP   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNMAP = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // classified request kinds passed from front to back
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_RANGE = 3'd0;
  localparam logic [KIND_W-1:0] K_READ  = 3'd1;
  localparam logic [KIND_W-1:0] K_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] K_MAP   = 3'd3;
  localparam logic [KIND_W-1:0] K_UNMAP = 3'd4;

  // page flag bits
  localparam int FLAGS_W = 3;
  localparam logic [FLAGS_W-1:0] FLAG_PRESENT = 3'b001;
  localparam logic [FLAGS_W-1:0] FLAG_USED    = 3'b010;
  localparam logic [FLAGS_W-1:0] FLAG_DIRTY   = 3'b100;

  // decoupling queue depth
  localparam int Q_DEPTH = 2;

endpackage

FILE: sv/ptt_queue.sv
// ---------------------------------------------------------------------------
// ptt_queue
// Small register FIFO between the classify front and the table back end.
// ---------------------------------------------------------------------------
module ptt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/ptt_front.sv
// ---------------------------------------------------------------------------
// ptt_front
// Accepts requests, splits addresses, checks ranges, stamps accesses and
// queues a classified request for the back end.
// ---------------------------------------------------------------------------
module ptt_front #(
  parameter int PAGE_WORDS = ptt_pkg::PAGE_WORDS_DEF,
  parameter int NUM_PAGES  = ptt_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = ptt_pkg::NUM_FRAMES_DEF,
  localparam int PG_W  = $clog2(NUM_PAGES),
  localparam int OFF_W = $clog2(PAGE_WORDS),
  localparam int FRM_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  localparam int ENT_W = ptt_pkg::KIND_W + PG_W + OFF_W + FRM_W
                         + ptt_pkg::DATA_W + ptt_pkg::STAMP_W
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 init_done,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [ptt_pkg::ACT_W-1:0]            in_action,
  input  logic [ptt_pkg::ADDR_W-1:0]           in_address,
  input  logic signed [ptt_pkg::DATA_W-1:0]    in_write_data,
  input  logic [ptt_pkg::FRAME_IN_W-1:0]       in_frame,
  output logic                                 q_push,
  output logic [ENT_W-1:0]                     q_wdata,
  input  logic                                 q_full
);

  // page = address / PAGE_WORDS by reciprocal multiply (exact for 16-bit addresses)
  localparam int RCP_SHIFT = ptt_pkg::ADDR_W + OFF_W;
  localparam int RCP_W     = ptt_pkg::ADDR_W + 1;
  localparam int PROD_W    = ptt_pkg::ADDR_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(PAGE_WORDS) - 64'd1) / 64'(PAGE_WORDS));

  typedef struct packed {
    logic [ptt_pkg::KIND_W-1:0]        kind;
    logic [PG_W-1:0]                   page;
    logic [OFF_W-1:0]                  offs;
    logic [FRM_W-1:0]                  frame;
    logic signed [ptt_pkg::DATA_W-1:0] wdata;
    logic [ptt_pkg::STAMP_W-1:0]       stamp;
  } entry_t;

  logic                               s1_valid_r, s1_valid_nxt;
  logic [ptt_pkg::ACT_W-1:0]          act_r;
  logic [ptt_pkg::ADDR_W-1:0]         addr_r;
  logic signed [ptt_pkg::DATA_W-1:0]  wdata_r;
  logic [ptt_pkg::FRAME_IN_W-1:0]     frame_r;
  logic [PROD_W-1:0]                  prod_r;
  logic [ptt_pkg::STAMP_W-1:0]        cnt_r, cnt_nxt;

  logic                               accept;
  logic                               is_access;
  logic                               out_of_range;
  logic [ptt_pkg::ADDR_W-1:0]         page16;
  logic [31:0]                        offs32;
  logic [31:0]                        frame32;
  entry_t                             ent;

  assign in_full = !init_done || (s1_valid_r && q_full);
  assign accept  = in_push && !in_full;
  assign q_push  = s1_valid_r && !q_full;

  // address split
  assign page16  = ptt_pkg::ADDR_W'(prod_r >> RCP_SHIFT);
  assign offs32  = 32'(addr_r) - 32'(page16) * 32'(PAGE_WORDS);
  assign frame32 = 32'(frame_r);

  // classification
  assign is_access = (act_r == ptt_pkg::ACT_READ) || (act_r == ptt_pkg::ACT_WRITE);

  always_comb begin
    if (is_access) begin
      out_of_range = (32'(page16) >= 32'(NUM_PAGES));
    end else begin
      out_of_range = (32'(addr_r) >= 32'(NUM_PAGES))
                  || ((act_r == ptt_pkg::ACT_MAP) && (frame32 >= 32'(NUM_FRAMES)));
    end
  end

  always_comb begin
    ent.page  = is_access ? PG_W'(page16) : PG_W'(addr_r);
    ent.offs  = OFF_W'(offs32);
    ent.frame = FRM_W'(frame32);
    ent.wdata = wdata_r;
    ent.stamp = cnt_r + 32'd1;
    if (out_of_range) begin
      ent.kind = ptt_pkg::K_RANGE;
    end else begin
      case (act_r)
        ptt_pkg::ACT_READ:  ent.kind = ptt_pkg::K_READ;
        ptt_pkg::ACT_WRITE: ent.kind = ptt_pkg::K_WRITE;
        ptt_pkg::ACT_MAP:   ent.kind = ptt_pkg::K_MAP;
        default:            ent.kind = ptt_pkg::K_UNMAP;
      endcase
    end
  end

  assign q_wdata = ent;

  // stage valid and access counter
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
    cnt_nxt = (q_push && is_access) ? cnt_r + 32'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // request capture with reciprocal product
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      frame_r <= in_frame;
      prod_r  <= PROD_W'(in_address) * PROD_W'(RCP_MUL);
    end
  end

endmodule

FILE: sv/ptt_back.sv
// ---------------------------------------------------------------------------
// ptt_back
// Page table and frame store sequencer: looks up the page entry, does the
// access or the map/unmap, and holds the result until it is popped.
// ---------------------------------------------------------------------------
`include "page_table_translate_assert.svh"

module ptt_back #(
  parameter int PAGE_WORDS = ptt_pkg::PAGE_WORDS_DEF,
  parameter int NUM_PAGES  = ptt_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = ptt_pkg::NUM_FRAMES_DEF,
  localparam int PG_W  = $clog2(NUM_PAGES),
  localparam int OFF_W = $clog2(PAGE_WORDS),
  localparam int FRM_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  localparam int WORDS = NUM_FRAMES * PAGE_WORDS,
  localparam int WA_W  = $clog2(WORDS),
  localparam int ENT_W = ptt_pkg::KIND_W + PG_W + OFF_W + FRM_W
                         + ptt_pkg::DATA_W + ptt_pkg::STAMP_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               init_done,
  input  logic                               q_empty,
  input  logic [ENT_W-1:0]                   q_rdata,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [ptt_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ptt_pkg::DATA_W-1:0]  out_read_data,
  output logic [ptt_pkg::FPAGE_W-1:0]        out_fault_page,
  output logic                               out_was_dirty,
  output logic [ptt_pkg::STAMP_W-1:0]        out_last_use
);

  typedef struct packed {
    logic [ptt_pkg::KIND_W-1:0]        kind;
    logic [PG_W-1:0]                   page;
    logic [OFF_W-1:0]                  offs;
    logic [FRM_W-1:0]                  frame;
    logic signed [ptt_pkg::DATA_W-1:0] wdata;
    logic [ptt_pkg::STAMP_W-1:0]       stamp;
  } entry_t;

  // sequencer states
  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_TBL  = 2'd2;
  localparam logic [1:0] S_WORD = 2'd3;

  // table and frame storage
  logic [ptt_pkg::FLAGS_W-1:0]  flags_mem [NUM_PAGES];
  logic [FRM_W-1:0]             frame_mem [NUM_PAGES];
  logic [ptt_pkg::STAMP_W-1:0]  stamp_mem [NUM_PAGES];
  logic [ptt_pkg::DATA_W-1:0]   word_mem  [WORDS];

  logic [1:0]                   state_r, state_nxt;
  logic [PG_W-1:0]              clr_idx_r, clr_idx_nxt;
  entry_t                       cur_r, cur_nxt;
  entry_t                       ent_q;

  logic [ptt_pkg::FLAGS_W-1:0]  flags_rd_r;
  logic [FRM_W-1:0]             frame_rd_r;
  logic [ptt_pkg::STAMP_W-1:0]  stamp_rd_r;
  logic [ptt_pkg::DATA_W-1:0]   word_rd_r;

  logic                         tbl_rd_en;
  logic                         flags_we;
  logic [PG_W-1:0]              flags_wa;
  logic [ptt_pkg::FLAGS_W-1:0]  flags_wd;
  logic                         frame_we;
  logic                         stamp_we;
  logic [ptt_pkg::STAMP_W-1:0]  stamp_wd;
  logic                         word_we;
  logic                         word_rd_en;
  logic [WA_W-1:0]              word_addr;
  logic                         present;

  logic                         res_valid_r, res_valid_nxt;
  logic                         res_load;
  logic                         out_free;
  logic [ptt_pkg::STATUS_W-1:0] res_status;
  logic [ptt_pkg::DATA_W-1:0]   res_rdata;
  logic [ptt_pkg::FPAGE_W-1:0]  res_fpage;
  logic                         res_dirty;
  logic [ptt_pkg::STAMP_W-1:0]  res_luse;

  assign ent_q     = entry_t'(q_rdata);
  assign init_done = (state_r != S_INIT);
  assign out_free  = !res_valid_r || out_pop;
  assign out_empty = !res_valid_r;
  assign present   = ((flags_rd_r & ptt_pkg::FLAG_PRESENT) != '0);
  assign word_addr = WA_W'(32'(frame_rd_r) * 32'(PAGE_WORDS) + 32'(cur_r.offs));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cur_nxt     = cur_r;
    q_pop       = 1'b0;
    tbl_rd_en   = 1'b0;
    flags_we    = 1'b0;
    flags_wa    = cur_r.page;
    flags_wd    = '0;
    frame_we    = 1'b0;
    stamp_we    = 1'b0;
    stamp_wd    = cur_r.stamp;
    word_we     = 1'b0;
    word_rd_en  = 1'b0;
    res_load    = 1'b0;
    res_status  = ptt_pkg::ST_OK;
    res_rdata   = '0;
    res_fpage   = '0;
    res_dirty   = 1'b0;
    res_luse    = '0;
    case (state_r)
      // clear every page's flags after reset
      S_INIT: begin
        flags_we = 1'b1;
        flags_wa = clr_idx_r;
        if (clr_idx_r == PG_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      // take the next request; range errors are answered here, without a table lookup
      S_IDLE: begin
        if (!q_empty) begin
          if (ent_q.kind == ptt_pkg::K_RANGE) begin
            if (out_free) begin
              q_pop      = 1'b1;
              res_load   = 1'b1;
              res_status = ptt_pkg::ST_RANGE;
            end
          end else begin
            q_pop     = 1'b1;
            tbl_rd_en = 1'b1;
            cur_nxt   = ent_q;
            state_nxt = S_TBL;
          end
        end
      end
      // page entry is available
      S_TBL: begin
        case (cur_r.kind)
          ptt_pkg::K_READ: begin
            if (present) begin
              flags_we   = 1'b1;
              flags_wd   = flags_rd_r | ptt_pkg::FLAG_USED;
              stamp_we   = 1'b1;
              word_rd_en = 1'b1;
              state_nxt  = S_WORD;
            end else if (out_free) begin
              res_load   = 1'b1;
              res_status = ptt_pkg::ST_FAULT;
              res_fpage  = ptt_pkg::FPAGE_W'(cur_r.page);
              state_nxt  = S_IDLE;
            end
          end
          ptt_pkg::K_WRITE: begin
            if (out_free) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (present) begin
                word_we  = 1'b1;
                flags_we = 1'b1;
                flags_wd = flags_rd_r | ptt_pkg::FLAG_USED | ptt_pkg::FLAG_DIRTY;
                stamp_we = 1'b1;
              end else begin
                res_status = ptt_pkg::ST_FAULT;
                res_fpage  = ptt_pkg::FPAGE_W'(cur_r.page);
              end
            end
          end
          ptt_pkg::K_MAP: begin
            if (out_free) begin
              res_load  = 1'b1;
              flags_we  = 1'b1;
              flags_wd  = ptt_pkg::FLAG_PRESENT;
              frame_we  = 1'b1;
              stamp_we  = 1'b1;
              stamp_wd  = '0;
              state_nxt = S_IDLE;
            end
          end
          ptt_pkg::K_UNMAP: begin
            if (out_free) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (present) begin
                flags_we  = 1'b1;
                res_dirty = ((flags_rd_r & ptt_pkg::FLAG_DIRTY) != '0);
                res_luse  = stamp_rd_r;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // frame word is available
      S_WORD: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_rdata = word_rd_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // page table memories
  always_ff @(posedge clk) begin
    if (flags_we) begin
      flags_mem[flags_wa] <= flags_wd;
    end
    if (tbl_rd_en) begin
      flags_rd_r <= flags_mem[ent_q.page];
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[cur_r.page] <= cur_r.frame;
    end
    if (tbl_rd_en) begin
      frame_rd_r <= frame_mem[ent_q.page];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[cur_r.page] <= stamp_wd;
    end
    if (tbl_rd_en) begin
      stamp_rd_r <= stamp_mem[ent_q.page];
    end
  end

  // frame word store
  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_addr] <= cur_r.wdata;
    end
    if (word_rd_en) begin
      word_rd_r <= word_mem[word_addr];
    end
  end

  // result register
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_load) begin
      res_valid_nxt = 1'b1;
    end else if (out_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status     <= res_status;
      out_read_data  <= res_rdata;
      out_fault_page <= res_fpage;
      out_was_dirty  <= res_dirty;
      out_last_use   <= res_luse;
    end
  end

  // checks
  `PTT_ASSERT_NOW(a_pop_in_idle, q_pop, state_r == S_IDLE, "queue popped outside idle")
  `PTT_ASSERT_NOW(a_load_when_free, res_load, out_free, "result overwrote a waiting one")
  `PTT_ASSERT_NOW(a_word_needs_present, (state_r == S_TBL) && (state_nxt == S_WORD), present, "word read for absent page")
  `PTT_ASSERT_NEXT(a_word_gives_result, (state_r == S_WORD) && out_free, res_valid_r, "read result lost")
  `PTT_ASSERT_NOW(a_clear_is_quiet, state_r == S_INIT, !q_pop && !res_load, "activity during clear")

endmodule

FILE: sv/page_table_translate.sv
// Flow: the sequencer answers an out-of-range request straight from idle; map,
//   unmap, write and page fault go through a page-table lookup, and a successful
//   read adds a frame-store read. The sequencer works on one request at a time;
//   the front takes 1 request per cycle while in_full is low.
// Reset: synchronous; afterwards a flag-clearing pass over all NUM_PAGES pages holds
//   in_full high before the first request is taken.
// ---------------------------------------------------------------------------
// page_table_translate
// Single-level page table translator with a frame data store, built as a
// classify front, a short queue and a table sequencer back end.
// ---------------------------------------------------------------------------
module page_table_translate #(
  parameter int PAGE_WORDS = ptt_pkg::PAGE_WORDS_DEF,
  parameter int NUM_PAGES  = ptt_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = ptt_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ptt_pkg::ACT_W-1:0]          in_action,
  input  logic [ptt_pkg::ADDR_W-1:0]         in_address,
  input  logic signed [ptt_pkg::DATA_W-1:0]  in_write_data,
  input  logic [ptt_pkg::FRAME_IN_W-1:0]     in_frame,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [ptt_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ptt_pkg::DATA_W-1:0]  out_read_data,
  output logic [ptt_pkg::FPAGE_W-1:0]        out_fault_page,
  output logic                               out_was_dirty,
  output logic [ptt_pkg::STAMP_W-1:0]        out_last_use
);

  localparam int PG_W  = $clog2(NUM_PAGES);
  localparam int OFF_W = $clog2(PAGE_WORDS);
  localparam int FRM_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int ENT_W = ptt_pkg::KIND_W + PG_W + OFF_W + FRM_W
                         + ptt_pkg::DATA_W + ptt_pkg::STAMP_W;

  logic             init_done;
  logic             q_push, q_full, q_pop, q_empty;
  logic [ENT_W-1:0] q_wdata, q_rdata;

  // request classification
  ptt_front #(
    .PAGE_WORDS (PAGE_WORDS),
    .NUM_PAGES  (NUM_PAGES),
    .NUM_FRAMES (NUM_FRAMES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .init_done     (init_done),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_frame      (in_frame),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  // decoupling queue
  ptt_queue #(
    .W     (ENT_W),
    .DEPTH (ptt_pkg::Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // table and frame store sequencer
  ptt_back #(
    .PAGE_WORDS (PAGE_WORDS),
    .NUM_PAGES  (NUM_PAGES),
    .NUM_FRAMES (NUM_FRAMES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .init_done      (init_done),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_fault_page (out_fault_page),
    .out_was_dirty  (out_was_dirty),
    .out_last_use   (out_last_use)
  );

endmodule

FILE: tb/tb_page_table_translate.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_page_table_translate
// Self-checking bench for the page table translator. Requests are built up
// front: a short directed set of edge cases, then a random mix of mostly
// in-range reads and writes with some map and unmap traffic. A clocked driver
// feeds them through the push/full port. A clocked monitor pops results against
// an in-bench translator model. Both sides idle at random, and the receiver
// holds off once long enough to back the block up.
// ---------------------------------------------------------------------------
module tb_page_table_translate;
  import ptt_pkg::*;

  localparam int PAGE_WORDS   = PAGE_WORDS_DEF;
  localparam int NUM_PAGES    = NUM_PAGES_DEF;
  localparam int NUM_FRAMES   = NUM_FRAMES_DEF;
  localparam int STORE_WORDS  = NUM_FRAMES * PAGE_WORDS;
  localparam int RANDOM_REQS  = 2000;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
    logic [FRAME_IN_W-1:0]    frame;
  } xlate_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_data;
    logic [FPAGE_W-1:0]       fault_page;
    logic                     was_dirty;
    logic [STAMP_W-1:0]       last_use;
  } xlate_rsp_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [ACT_W-1:0]           in_action = ACT_READ;
  logic [ADDR_W-1:0]          in_address = '0;
  logic signed [DATA_W-1:0]   in_write_data = '0;
  logic [FRAME_IN_W-1:0]      in_frame = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic signed [DATA_W-1:0]   out_read_data;
  logic [FPAGE_W-1:0]         out_fault_page;
  logic                       out_was_dirty;
  logic [STAMP_W-1:0]         out_last_use;

  page_table_translate dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_frame       (in_frame),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_fault_page (out_fault_page),
    .out_was_dirty  (out_was_dirty),
    .out_last_use   (out_last_use)
  );

  // model state of the translator
  logic [FLAGS_W-1:0]       pt_flags [NUM_PAGES];
  logic [FRAME_IN_W-1:0]    pt_frame [NUM_PAGES];
  logic [STAMP_W-1:0]       pt_stamp [NUM_PAGES];
  logic [DATA_W-1:0]        frame_mem [STORE_WORDS];
  logic [STAMP_W-1:0]       access_count;

  // generator view: which pages are mapped and which frame words hold data
  bit                       gen_present [NUM_PAGES];
  int unsigned              gen_frame [NUM_PAGES];
  bit                       word_written [STORE_WORDS];

  xlate_req_t               pending_reqs [$];
  xlate_rsp_t               expected_results [$];
  int unsigned              reqs_sent = 0;
  int unsigned              results_seen = 0;
  int unsigned              send_gap = 0;
  int unsigned              pop_gap = 0;
  int unsigned              hold_left = 0;
  bit                       hold_done = 1'b0;
  int unsigned              idle_cycles = 0;
  int unsigned              error_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // translate one request and update the model state
  function automatic xlate_rsp_t translate(xlate_req_t r);
    xlate_rsp_t  o;
    int unsigned pg;
    int unsigned off;
    int unsigned idx;
    o = '0;
    o.status = ST_OK;
    if (r.action == ACT_READ || r.action == ACT_WRITE) begin
      pg = r.address / PAGE_WORDS;
      off = r.address % PAGE_WORDS;
      access_count = access_count + 1;
      if (pg >= NUM_PAGES) begin
        o.status = ST_RANGE;
      end else if ((pt_flags[pg] & FLAG_PRESENT) == '0) begin
        o.status = ST_FAULT;
        o.fault_page = FPAGE_W'(pg);
      end else begin
        idx = pt_frame[pg] * PAGE_WORDS + off;
        if (r.action == ACT_READ) begin
          o.read_data = frame_mem[idx];
          pt_flags[pg] = pt_flags[pg] | FLAG_USED;
        end else begin
          frame_mem[idx] = r.write_data;
          pt_flags[pg] = pt_flags[pg] | FLAG_USED | FLAG_DIRTY;
        end
        pt_stamp[pg] = access_count;
      end
    end else if (r.action == ACT_MAP) begin
      if (r.address >= NUM_PAGES || r.frame >= NUM_FRAMES) begin
        o.status = ST_RANGE;
      end else begin
        pt_flags[r.address] = FLAG_PRESENT;
        pt_frame[r.address] = r.frame;
        pt_stamp[r.address] = '0;
      end
    end else begin
      if (r.address >= NUM_PAGES) begin
        o.status = ST_RANGE;
      end else if ((pt_flags[r.address] & FLAG_PRESENT) != '0) begin
        o.was_dirty = (pt_flags[r.address] & FLAG_DIRTY) != '0;
        o.last_use = pt_stamp[r.address];
        pt_flags[r.address] = '0;
      end
    end
    return o;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // queue a request; a read of a never-written frame word becomes a write
  task automatic add_req(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                         logic [DATA_W-1:0] data, logic [FRAME_IN_W-1:0] frm);
    xlate_req_t  r;
    int unsigned pg;
    int unsigned idx;
    pg = addr / PAGE_WORDS;
    if ((act == ACT_READ || act == ACT_WRITE) && pg < NUM_PAGES && gen_present[pg]) begin
      idx = gen_frame[pg] * PAGE_WORDS + addr % PAGE_WORDS;
      if (!word_written[idx]) act = ACT_WRITE;
      if (act == ACT_WRITE) word_written[idx] = 1'b1;
    end else if (act == ACT_MAP && addr < NUM_PAGES) begin
      gen_present[addr] = 1'b1;
      gen_frame[addr] = frm;
    end else if (act == ACT_UNMAP && addr < NUM_PAGES) begin
      gen_present[addr] = 1'b0;
    end
    r.action = act;
    r.address = addr;
    r.write_data = data;
    r.frame = frm;
    pending_reqs.push_back(r);
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned kind;
    int unsigned pg;
    int unsigned tries;
    for (int i = 0; i < NUM_PAGES; i++) begin
      pt_flags[i] = '0;
      pt_frame[i] = '0;
      pt_stamp[i] = '0;
      gen_present[i] = 1'b0;
      gen_frame[i] = 0;
    end
    for (int i = 0; i < STORE_WORDS; i++) begin
      frame_mem[i] = '0;
      word_written[i] = 1'b0;
    end
    access_count = '0;

    // directed: faults, range errors, extremes, remap, unmap of absent page
    add_req(ACT_READ,  16'h0000, 32'h0, 4'h0);
    add_req(ACT_WRITE, 16'hFFFF, 32'h7FFFFFFF, 4'hF);
    add_req(ACT_READ,  16'h0400, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'h0005, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'hFFFF, 32'h0, 4'h0);
    add_req(ACT_MAP,   16'h0080, 32'h0, 4'h3);
    add_req(ACT_MAP,   16'hFFFF, 32'hFFFFFFFF, 4'hF);
    add_req(ACT_MAP,   16'h0000, 32'h0, 4'h0);
    add_req(ACT_MAP,   16'h007F, 32'h0, 4'hF);
    add_req(ACT_WRITE, 16'h0000, 32'h7FFFFFFF, 4'h0);
    add_req(ACT_WRITE, 16'h0007, 32'h80000000, 4'h0);
    add_req(ACT_READ,  16'h0000, 32'h0, 4'h0);
    add_req(ACT_READ,  16'h0007, 32'h0, 4'h0);
    add_req(ACT_WRITE, 16'h03FF, 32'hFFFFFFFF, 4'h0);
    add_req(ACT_READ,  16'h03FF, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'h007F, 32'h0, 4'h0);
    add_req(ACT_READ,  16'h03FF, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'h007F, 32'h0, 4'h0);
    add_req(ACT_MAP,   16'h0001, 32'h0, 4'h0);
    add_req(ACT_READ,  16'h0008, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'h0001, 32'h0, 4'h0);
    add_req(ACT_MAP,   16'h0000, 32'h0, 4'h0);
    add_req(ACT_UNMAP, 16'h0000, 32'h0, 4'h0);

    // random: mostly accesses to mapped pages, some map/unmap churn
    for (int n = 0; n < RANDOM_REQS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8 || kind < 14) begin
        pg = ($urandom_range(0, 9) != 0) ? $urandom_range(0, NUM_PAGES - 1)
                                         : $urandom_range(0, 16'hFFFF);
        add_req(kind < 8 ? ACT_MAP : ACT_UNMAP, ADDR_W'(pg), $urandom,
                FRAME_IN_W'($urandom));
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          pg = $urandom_range(0, NUM_PAGES - 1);
          tries = 0;
          while (!gen_present[pg] && tries < 16) begin
            pg = $urandom_range(0, NUM_PAGES - 1);
            tries++;
          end
          pg = pg * PAGE_WORDS + $urandom_range(0, PAGE_WORDS - 1);
        end else if (kind < 92) begin
          pg = $urandom_range(0, NUM_PAGES * PAGE_WORDS - 1);
        end else begin
          pg = $urandom_range(0, 16'hFFFF);
        end
        add_req($urandom_range(0, 99) < 45 ? ACT_WRITE : ACT_READ, ADDR_W'(pg),
                $urandom, FRAME_IN_W'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // request driver: holds the head request until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expected_results.push_back(translate(pending_reqs.pop_front()));
        reqs_sent++;
        // every third stretch of 150 requests runs without gaps
        if ((reqs_sent / 150) % 3 != 0) send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_push <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_push <= 1'b1;
        in_action <= pending_reqs[0].action;
        in_address <= pending_reqs[0].address;
        in_write_data <= pending_reqs[0].write_data;
        in_frame <= pending_reqs[0].frame;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    xlate_rsp_t exp_rsp;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result popped with no request outstanding");
          error_count++;
        end else begin
          exp_rsp = expected_results.pop_front();
          if (out_status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_status);
            error_count++;
          end
          if (out_read_data !== exp_rsp.read_data) begin
            $error("read_data: expected %0d, got %0d", exp_rsp.read_data, out_read_data);
            error_count++;
          end
          if (out_fault_page !== exp_rsp.fault_page) begin
            $error("fault_page: expected %0d, got %0d", exp_rsp.fault_page, out_fault_page);
            error_count++;
          end
          if (out_was_dirty !== exp_rsp.was_dirty) begin
            $error("was_dirty: expected %0d, got %0d", exp_rsp.was_dirty, out_was_dirty);
            error_count++;
          end
          if (out_last_use !== exp_rsp.last_use) begin
            $error("last_use: expected %0d, got %0d", exp_rsp.last_use, out_last_use);
            error_count++;
          end
        end
        results_seen++;
        if ((results_seen / 150) % 3 != 1) pop_gap = pick_gap();
      end
      // one long hold-off so the block backs up and raises full
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
